// File: rtl/core/cpl_pkg.sv
// Shared types and constants for the correlation peak locator.
package cpl_pkg;

  localparam int unsigned CFG_W    = 9;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SHIFT_W  = 9;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [CFG_W-1:0]    ROW_COUNT_RST = CFG_W'(128);
  localparam logic [CFG_W-1:0]    COL_COUNT_RST = CFG_W'(128);
  localparam logic [SAMPLE_W-1:0] PEAK_RST      = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cpl_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
  } cpl_dims_t;

endpackage

// File: rtl/core/cpl_apb_regs.sv
// Configuration registers behind the APB port, with clamped map dimensions.
module cpl_apb_regs #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cpl_pkg::APB_AW-1:0]       paddr,
  input  logic [cpl_pkg::APB_DW-1:0]       pwdata,
  output logic [cpl_pkg::APB_DW-1:0]       prdata,
  output logic                             pready,
  output cpl_pkg::cpl_dims_t               dims_o
);

  logic [cpl_pkg::CFG_W-1:0] row_count_q, row_count_d;
  logic [cpl_pkg::CFG_W-1:0] col_count_q, col_count_d;
  cpl_pkg::cpl_reg_e         reg_sel;
  logic                      wr_en;

  function automatic logic [cpl_pkg::CFG_W-1:0] clamp_count(logic [cpl_pkg::CFG_W-1:0] v);
    logic [cpl_pkg::CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = cpl_pkg::CFG_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = cpl_pkg::CFG_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign pready  = 1'b1;
  assign reg_sel = cpl_pkg::cpl_reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    prdata      = '0;
    unique case (reg_sel)
      cpl_pkg::REG_ROW_COUNT: begin
        prdata = cpl_pkg::APB_DW'(row_count_q);
        if (wr_en) row_count_d = pwdata[cpl_pkg::CFG_W-1:0];
      end
      cpl_pkg::REG_COL_COUNT: begin
        prdata = cpl_pkg::APB_DW'(col_count_q);
        if (wr_en) col_count_d = pwdata[cpl_pkg::CFG_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= cpl_pkg::ROW_COUNT_RST;
      col_count_q <= cpl_pkg::COL_COUNT_RST;
    end else begin
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
    end
  end

  assign dims_o.rows = clamp_count(row_count_q);
  assign dims_o.cols = clamp_count(col_count_q);

endmodule

// File: rtl/core/cpl_peak_track.sv
// Input register, running maximum and row/column position counters.
module cpl_peak_track #(
  parameter int unsigned MAX_DIM = 256,
  parameter int unsigned CW      = $clog2(MAX_DIM)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cpl_pkg::SAMPLE_W-1:0] sample_real_i,
  input  cpl_pkg::cpl_dims_t                  dims_i,
  input  logic                                res_busy_i,
  output logic                                res_load_o,
  output logic signed [cpl_pkg::SAMPLE_W-1:0] res_value_o,
  output logic [CW-1:0]                       res_row_o,
  output logic [CW-1:0]                       res_col_o
);

  localparam int unsigned XW = ((CW > cpl_pkg::CFG_W) ? CW : cpl_pkg::CFG_W) + 1;

  logic                                s1_valid_q, s1_valid_d;
  logic signed [cpl_pkg::SAMPLE_W-1:0] s1_sample_q, s1_sample_d;
  logic signed [cpl_pkg::SAMPLE_W-1:0] best_value_q, best_value_d;
  logic [CW-1:0]                       best_row_q, best_row_d;
  logic [CW-1:0]                       best_col_q, best_col_d;
  logic [CW-1:0]                       cur_row_q, cur_row_d;
  logic [CW-1:0]                       cur_col_q, cur_col_d;

  logic [XW-1:0] col_next, row_next;
  logic          col_end, row_end, map_end;
  logic          advance, accept, better;
  logic signed [cpl_pkg::SAMPLE_W-1:0] upd_value;
  logic [CW-1:0] upd_row, upd_col;

  assign col_next = XW'(cur_col_q) + XW'(1);
  assign row_next = XW'(cur_row_q) + XW'(1);
  assign col_end  = col_next >= XW'(dims_i.cols);
  assign row_end  = row_next >= XW'(dims_i.rows);
  assign map_end  = col_end && row_end;

  // hold the sample while a finished map waits on a full result register
  assign advance    = s1_valid_q && !(map_end && res_busy_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign better    = s1_sample_q > best_value_q;
  assign upd_value = better ? s1_sample_q : best_value_q;
  assign upd_row   = better ? cur_row_q : best_row_q;
  assign upd_col   = better ? cur_col_q : best_col_q;

  assign res_load_o  = advance && map_end;
  assign res_value_o = upd_value;
  assign res_row_o   = upd_row;
  assign res_col_o   = upd_col;

  always_comb begin
    s1_valid_d   = s1_valid_q;
    s1_sample_d  = s1_sample_q;
    best_value_d = best_value_q;
    best_row_d   = best_row_q;
    best_col_d   = best_col_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    if (advance) begin
      s1_valid_d = 1'b0;
      if (map_end) begin
        best_value_d = cpl_pkg::PEAK_RST;
        best_row_d   = '0;
        best_col_d   = '0;
        cur_row_d    = '0;
        cur_col_d    = '0;
      end else begin
        best_value_d = upd_value;
        best_row_d   = upd_row;
        best_col_d   = upd_col;
        if (col_end) begin
          cur_col_d = '0;
          cur_row_d = row_next[CW-1:0];
        end else begin
          cur_col_d = col_next[CW-1:0];
        end
      end
    end
    if (accept) begin
      s1_valid_d  = 1'b1;
      s1_sample_d = sample_real_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      best_value_q <= cpl_pkg::PEAK_RST;
      best_row_q   <= '0;
      best_col_q   <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      best_value_q <= best_value_d;
      best_row_q   <= best_row_d;
      best_col_q   <= best_col_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sample_q <= s1_sample_d;
  end

endmodule

// File: rtl/core/cpl_result_reg.sv
// Wraparound of the peak position and the registered result beat.
module cpl_result_reg #(
  parameter int unsigned MAX_DIM = 256,
  parameter int unsigned CW      = $clog2(MAX_DIM)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic signed [cpl_pkg::SAMPLE_W-1:0] value_i,
  input  logic [CW-1:0]                       row_i,
  input  logic [CW-1:0]                       col_i,
  input  cpl_pkg::cpl_dims_t                  dims_i,
  output logic                                busy_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cpl_pkg::SHIFT_W-1:0]  row_shift_o,
  output logic signed [cpl_pkg::SHIFT_W-1:0]  col_shift_o,
  output logic signed [cpl_pkg::SAMPLE_W-1:0] peak_value_o
);

  localparam int unsigned XW = ((CW > cpl_pkg::CFG_W) ? CW : cpl_pkg::CFG_W) + 1;

  logic                                valid_q, valid_d;
  logic signed [cpl_pkg::SHIFT_W-1:0]  row_shift_q, row_shift_d;
  logic signed [cpl_pkg::SHIFT_W-1:0]  col_shift_q, col_shift_d;
  logic signed [cpl_pkg::SAMPLE_W-1:0] peak_q, peak_d;

  function automatic logic [cpl_pkg::SHIFT_W-1:0] wrap(logic [CW-1:0] pos,
                                                      logic [cpl_pkg::CFG_W-1:0] n);
    logic [XW-1:0] d;
    d = XW'(pos);
    if (XW'(pos) > XW'(n >> 1)) begin
      d = XW'(pos) - XW'(n);
    end
    return d[cpl_pkg::SHIFT_W-1:0];
  endfunction

  assign busy_o = valid_q && out_stall_i;

  always_comb begin
    valid_d     = valid_q;
    row_shift_d = row_shift_q;
    col_shift_d = col_shift_q;
    peak_d      = peak_q;
    if (valid_q && !out_stall_i) valid_d = 1'b0;
    if (load_i) begin
      valid_d     = 1'b1;
      row_shift_d = wrap(row_i, dims_i.rows);
      col_shift_d = wrap(col_i, dims_i.cols);
      peak_d      = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_shift_q <= row_shift_d;
    col_shift_q <= col_shift_d;
    peak_q      <= peak_d;
  end

  assign out_valid_o  = valid_q;
  assign row_shift_o  = row_shift_q;
  assign col_shift_o  = col_shift_q;
  assign peak_value_o = peak_q;

endmodule

// File: rtl/core/correlation_peak_locator.sv
// Top level of the correlation peak locator.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | sink      | in_valid_i/in_stall_o  | sample_real_i
//   out     | source    | out_valid_o/out_stall_i| row_shift_o, col_shift_o, peak_value_o
//   cfg     | APB slave | psel/penable/pready    | paddr, pwdata, prdata
//
// One sample a cycle unless the input stalls: each sample is held in the input register,
// where the compare and the position counters act, and a map's result is loaded into the
// output register from there once its last sample has been compared.
// Reset clears the counters and both valid flags and sets the running peak to the most
// negative value; the registers return to 128 rows and 128 columns. A stalled result only
// stops the input when the sample waiting in the input register would finish the next map.
module correlation_peak_locator #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cpl_pkg::SAMPLE_W-1:0] sample_real_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cpl_pkg::SHIFT_W-1:0]  row_shift_o,
  output logic signed [cpl_pkg::SHIFT_W-1:0]  col_shift_o,
  output logic signed [cpl_pkg::SAMPLE_W-1:0] peak_value_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cpl_pkg::APB_AW-1:0]          paddr,
  input  logic [cpl_pkg::APB_DW-1:0]          pwdata,
  output logic [cpl_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int unsigned CW = $clog2(MAX_DIM);

  cpl_pkg::cpl_dims_t                  dims;
  logic                                res_busy;
  logic                                res_load;
  logic signed [cpl_pkg::SAMPLE_W-1:0] res_value;
  logic [CW-1:0]                       res_row;
  logic [CW-1:0]                       res_col;

  cpl_apb_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims_o  (dims)
  );

  cpl_peak_track #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_real_i (sample_real_i),
    .dims_i        (dims),
    .res_busy_i    (res_busy),
    .res_load_o    (res_load),
    .res_value_o   (res_value),
    .res_row_o     (res_row),
    .res_col_o     (res_col)
  );

  cpl_result_reg #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW)
  ) u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (res_load),
    .value_i      (res_value),
    .row_i        (res_row),
    .col_i        (res_col),
    .dims_i       (dims),
    .busy_o       (res_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_shift_o  (row_shift_o),
    .col_shift_o  (col_shift_o),
    .peak_value_o (peak_value_o)
  );

endmodule
